@@ rtl/utf8_pkg.sv @@
// utf8_pkg: item types, byte-class constants and the overlong check for the
// UTF-8 stream decoder. No dependencies.
`timescale 1ns / 1ps

package utf8_pkg;

	localparam int CpWidth  = 21;
	localparam int LenWidth = 3;

	typedef logic [CpWidth-1:0]  cp_t;
	typedef logic [LenWidth-1:0] len_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} utf8_in_t;

	typedef struct packed {
		cp_t  code_point;
		logic invalid;
		len_t bytes_used;
	} utf8_out_t;

	localparam logic [7:0] LEAD_MIN   = 8'hC2;
	localparam logic [7:0] LEAD_MAX   = 8'hF4;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] LEAD_MASK  = 8'h7F;
	localparam logic [1:0] TAIL_TAG   = 2'b10;
	localparam logic [9:0] SURR_HI    = 10'h1B;
	localparam cp_t        CP_MAX     = 21'h10FFFF;
	localparam cp_t        INVALID_RST = 21'h00FFFD;

	localparam len_t LEN_NONE = 3'd0;
	localparam len_t LEN_ONE  = 3'd1;
	localparam len_t LEN_TWO  = 3'd2;
	localparam len_t LEN_THREE = 3'd3;
	localparam len_t LEN_FOUR = 3'd4;

	// true when cp is below the shortest value the sequence length may encode
	function automatic logic below_min(input len_t len, input cp_t cp);
		logic r;
		begin
			unique case (len)
				LEN_NONE:  r = 1'b1;
				LEN_TWO:   r = (cp < 21'd128);
				LEN_THREE: r = (cp < 21'd2048);
				LEN_FOUR:  r = (cp < 21'd65536);
				default:   r = 1'b0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ rtl/utf8_stream_decoder.sv @@
// utf8_stream_decoder: byte-wide UTF-8 decoder, one code point per sequence.
// Depends on utf8_pkg for the item types and constants.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall   | utf8_in_t  (in_byte, end_of_input)
//  out     | out       | out_valid/out_stall | utf8_out_t (code_point, invalid, bytes_used)
//  cfg     | in        | cfg_we              | cfg_wdata  (invalid_value)
//
// One byte is taken every cycle while in_stall is low; the byte that completes
// a sequence is held in the input register, and its result leaves through the result register.
// The rate is set by the sequence state update, one byte per cycle when not stalled.
// Reset clears both stages, closes any open sequence and sets invalid_value
// to 0xFFFD. A stall on out holds the result register and backs up to in
// only when the input register also holds a byte.
`timescale 1ns / 1ps

module utf8_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  utf8_pkg::utf8_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output utf8_pkg::utf8_out_t out_data,
	input  logic                cfg_we,
	input  utf8_pkg::cp_t       cfg_wdata
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eoi_s1;
	logic                out_valid_s2;
	utf8_pkg::utf8_out_t out_data_s2;

	utf8_pkg::cp_t  invalid_value_q;
	utf8_pkg::len_t seq_len_q;
	utf8_pkg::len_t seen_q;
	utf8_pkg::cp_t  acc_q;
	logic           terr_q;

	utf8_pkg::len_t seq_len_d;
	utf8_pkg::len_t seen_d;
	utf8_pkg::cp_t  acc_d;
	logic           terr_d;

	utf8_pkg::len_t lead_len;
	utf8_pkg::len_t seen_inc;
	utf8_pkg::cp_t  acc_shift;
	logic           terr_shift;
	logic           res_v;
	utf8_pkg::cp_t  res_cp;
	logic           res_bad;
	utf8_pkg::len_t res_used;

	logic out_free;
	logic s1_fire;

	assign out_free = !out_valid_s2 || !out_stall;
	assign s1_fire  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

	always_comb begin
		lead_len = (byte_s1 >= utf8_pkg::LEAD4_MIN) ? utf8_pkg::LEN_FOUR :
			(byte_s1 >= utf8_pkg::LEAD3_MIN) ? utf8_pkg::LEN_THREE : utf8_pkg::LEN_TWO;
		seen_inc   = seen_q + utf8_pkg::LEN_ONE;
		acc_shift  = {acc_q[utf8_pkg::CpWidth-7:0], byte_s1[5:0]};
		terr_shift = terr_q || (byte_s1[7:6] != utf8_pkg::TAIL_TAG);

		seq_len_d = seq_len_q;
		seen_d    = seen_q;
		acc_d     = acc_q;
		terr_d    = terr_q;
		res_v     = 1'b0;
		res_cp    = '0;
		res_bad   = 1'b0;
		res_used  = utf8_pkg::LEN_NONE;

		if (seq_len_q == utf8_pkg::LEN_NONE) begin
			if (byte_s1 < utf8_pkg::LEAD_MIN || byte_s1 > utf8_pkg::LEAD_MAX) begin
				// single-byte item: ascii or a stray byte
				res_v    = 1'b1;
				res_cp   = {13'd0, byte_s1};
				res_bad  = byte_s1[7];
				res_used = utf8_pkg::LEN_ONE;
			end else if (eoi_s1) begin
				res_v    = 1'b1;
				res_bad  = 1'b1;
				res_used = utf8_pkg::LEN_ONE;
			end else begin
				seq_len_d = lead_len;
				seen_d    = utf8_pkg::LEN_ONE;
				acc_d     = {13'd0, byte_s1 & (utf8_pkg::LEAD_MASK >> lead_len)};
				terr_d    = 1'b0;
			end
		end else begin
			if (seen_inc >= seq_len_q) begin
				res_v    = 1'b1;
				res_cp   = acc_shift;
				res_bad  = terr_shift
					|| utf8_pkg::below_min(seq_len_q, acc_shift)
					|| (acc_shift[20:11] == utf8_pkg::SURR_HI)
					|| (acc_shift > utf8_pkg::CP_MAX);
				res_used = seq_len_q;
				seq_len_d = utf8_pkg::LEN_NONE;
				seen_d    = utf8_pkg::LEN_NONE;
				acc_d     = '0;
				terr_d    = 1'b0;
			end else if (eoi_s1) begin
				// sequence cut short by end of input
				res_v    = 1'b1;
				res_bad  = 1'b1;
				res_used = seen_inc;
				seq_len_d = utf8_pkg::LEN_NONE;
				seen_d    = utf8_pkg::LEN_NONE;
				acc_d     = '0;
				terr_d    = 1'b0;
			end else begin
				seen_d = seen_inc;
				acc_d  = acc_shift;
				terr_d = terr_shift;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_value_q <= utf8_pkg::INVALID_RST;
		end else if (cfg_we) begin
			invalid_value_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_data.in_byte;
			eoi_s1  <= in_data.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= utf8_pkg::LEN_NONE;
			seen_q    <= utf8_pkg::LEN_NONE;
			acc_q     <= '0;
			terr_q    <= 1'b0;
		end else if (s1_fire) begin
			seq_len_q <= seq_len_d;
			seen_q    <= seen_d;
			acc_q     <= acc_d;
			terr_q    <= terr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= s1_fire && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_v) begin
			out_data_s2.code_point <= res_bad ? invalid_value_q : res_cp;
			out_data_s2.invalid    <= res_bad;
			out_data_s2.bytes_used <= res_used;
		end
	end

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> (out_data_s2.bytes_used != utf8_pkg::LEN_NONE
			&& out_data_s2.bytes_used <= utf8_pkg::LEN_FOUR))
		else $error("bytes_used out of range");

	a_good_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !out_data_s2.invalid) |->
			(out_data_s2.code_point <= utf8_pkg::CP_MAX
			&& out_data_s2.code_point[20:11] != utf8_pkg::SURR_HI))
		else $error("valid result is a surrogate or out of range");

	a_bad_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && out_data_s2.invalid) |->
			(out_data_s2.code_point == invalid_value_q))
		else $error("invalid result without replacement value");

	a_seq_state: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_len_q == utf8_pkg::LEN_NONE) ?
			(seen_q == utf8_pkg::LEN_NONE && acc_q == '0 && !terr_q) :
			(seen_q != utf8_pkg::LEN_NONE && seen_q < seq_len_q))
		else $error("open sequence state inconsistent");

endmodule
